@@ rtl/lir_pkg.sv @@
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every rtl file imports this package.
package lir_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int RATE_W        = 18;
    localparam int CNT_W         = 32;
    localparam int HISTORY_DEPTH = 64;
    localparam int RING_AW       = $clog2(HISTORY_DEPTH);
    localparam int MAX_RATIO     = 32;
    localparam int RATIO_W       = RATE_W + $clog2(MAX_RATIO + 1);
    localparam int RESULT_CAP    = 64;
    localparam int CAP_W         = $clog2(RESULT_CAP + 1);
    localparam int LIM_W         = CNT_W + RATE_W;
    localparam int DIVN_W        = 2 * RATE_W - 1;
    localparam int DIVQ_W        = $clog2(RATE_W + 1);
    localparam int DIVS_W        = $clog2(DIVN_W + 1);
    localparam int CFG_AW        = 1;
    localparam int TUSER_W       = 2;

    // quotient bit counts for the three divide kinds
    localparam logic [DIVQ_W-1:0] QB_FOLD   = DIVQ_W'(RATE_W);
    localparam logic [DIVQ_W-1:0] QB_INTERP = DIVQ_W'(SAMPLE_W);
    localparam logic [DIVQ_W-1:0] QB_STEP   = DIVQ_W'($clog2(MAX_RATIO + 1));

    localparam logic [CFG_AW-1:0] REG_SOURCE_RATE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_TARGET_RATE = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_FOLD,
        ST_FOLD_WAIT,
        ST_CHK,
        ST_CMP,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_IDIV,
        ST_IDIV_WAIT,
        ST_EMIT,
        ST_SDIV_WAIT,
        ST_FIN
    } t_state;

endpackage

@@ rtl/lir_ring.sv @@
// Sample history memory: one write port, one read port, registered read data.
// Depends on lir_pkg.
module lir_ring (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [lir_pkg::RING_AW-1:0]       i_waddr,
    input  logic [lir_pkg::SAMPLE_W-1:0]      i_wdata,
    input  logic [lir_pkg::RING_AW-1:0]       i_raddr,
    output logic [lir_pkg::SAMPLE_W-1:0]      o_rdata
);
    import lir_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lir_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient width chosen per start.
// Caller guarantees num < den * 2^qbits. Depends on lir_pkg.
module lir_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lir_pkg::DIVN_W-1:0]    i_num,
    input  logic [lir_pkg::RATE_W-1:0]    i_den,
    input  logic [lir_pkg::DIVQ_W-1:0]    i_qbits,
    output logic                          o_busy,
    output logic [lir_pkg::RATE_W-1:0]    o_quo,
    output logic [lir_pkg::RATE_W-1:0]    o_rem
);
    import lir_pkg::*;

    logic                r_busy;
    logic [DIVQ_W-1:0]   r_cnt;
    logic [RATE_W-1:0]   r_rem;
    logic [RATE_W-1:0]   r_quo;
    logic [RATE_W-1:0]   r_den;
    logic [DIVN_W-1:0]   r_num;
    logic [RATE_W:0]     trial;
    logic                fits;

    assign trial = {r_rem, r_num[DIVN_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == DIVQ_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= i_qbits;
            r_den <= i_den;
            r_quo <= '0;
            r_rem <= RATE_W'(i_num >> i_qbits);
            r_num <= i_num << (DIVS_W'(DIVN_W) - DIVS_W'(i_qbits));
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIVQ_W'(1);
            r_num <= r_num << 1;
            r_quo <= {r_quo[RATE_W-2:0], fits};
            r_rem <= fits ? RATE_W'(trial - {1'b0, r_den}) : trial[RATE_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/linear_interp_resampler.sv @@
// Linear interpolation sample rate converter, top level.
// Depends on lir_pkg, lir_ring, lir_div.
//
// Input stream: tdata carries one signed 16-bit PCM sample, tlast marks the
// final sample of a stream. Output stream: tdata carries one resampled
// sample, tlast marks the last output caused by an input transaction,
// tuser[0] marks the final output of the stream, tuser[1] flags a rate ratio
// beyond 32:1 (or a zero rate); such a transaction gives one output of zero.
// Rates are to be written on the config port while the block is idle (not enforced).
// One input is worked on at a time; tready is high only when idle.
// Per input: a fold divide when a rate change left the phase out of range;
// per output produced, two reads of the sample memory's single read port,
// then the shared divider for the interpolation quotient and again for the
// position step. Each output is held back until the following one is known
// or the transaction ends, so run ends can be marked. The output register
// lets the core keep working while the receiver stalls; it waits only when
// it must pass a result on while the output register is still full. Reset
// sets both rates to 16000 and clears the stream position; the sample
// memory needs no clearing. End of stream clears the position.
module linear_interp_resampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lir_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [lir_pkg::RATE_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [lir_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,  // [15:0] in_sample
    input  logic                              i_s_axis_tlast,  // end_of_stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [lir_pkg::SAMPLE_W-1:0]      o_m_axis_tdata,  // [15:0] out_sample
    output logic                              o_m_axis_tlast,  // run_last
    output logic [lir_pkg::TUSER_W-1:0]       o_m_axis_tuser   // [0] stream_done, [1] ratio_error
);
    import lir_pkg::*;

    t_state r_state, n_state;

    logic [RATE_W-1:0]   r_src, r_tgt;
    logic [CNT_W-1:0]    r_seen, n_seen;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [RATE_W-1:0]   r_p, n_p;
    logic [RING_AW-1:0]  r_wr, n_wr;
    logic [CAP_W-1:0]    r_cnt, n_cnt;
    logic                r_eos, n_eos;
    logic [CNT_W-1:0]    r_d, n_d;
    logic [LIM_W-1:0]    r_lim, n_lim;
    logic [SAMPLE_W-1:0] r_x0, n_x0;
    logic [SAMPLE_W-1:0] r_x1, n_x1;
    logic [DIVN_W-1:0]   r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [SAMPLE_W-1:0] r_val, n_val;
    logic                r_hold_v, n_hold_v;
    logic [SAMPLE_W-1:0] r_hold_d, n_hold_d;
    logic                r_ov, n_ov;
    logic [SAMPLE_W-1:0] r_od, n_od;
    logic                r_olast, n_olast;
    logic [TUSER_W-1:0]  r_ouser, n_ouser;

    logic                mem_we;
    logic [RING_AW-1:0]  mem_raddr;
    logic [SAMPLE_W-1:0] mem_rdata;
    logic                div_start, div_busy;
    logic [DIVN_W-1:0]   div_num;
    logic [DIVQ_W-1:0]   div_qbits;
    logic [RATE_W-1:0]   div_quo, div_rem;

    logic                ratio_bad, out_free, accept;
    logic [RATIO_W-1:0]  src_x, tgt_x;
    logic [RATE_W:0]     p_next;
    logic [SAMPLE_W:0]   diff;
    logic [DIVN_W-1:0]   prod;
    logic [SAMPLE_W:0]   q_ext, val_ext;

    assign src_x     = RATIO_W'(r_src) * RATIO_W'(MAX_RATIO);
    assign tgt_x     = RATIO_W'(r_tgt) * RATIO_W'(MAX_RATIO);
    assign ratio_bad = (r_src == '0) || (r_tgt == '0)
                       || (RATIO_W'(r_tgt) > src_x) || (RATIO_W'(r_src) > tgt_x);
    assign out_free  = !r_ov || i_m_axis_tready;
    assign accept    = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign p_next    = {1'b0, r_p} + {1'b0, r_src};

    assign diff  = (r_d >= CNT_W'(2))
                   ? ({r_x1[SAMPLE_W-1], r_x1} - {r_x0[SAMPLE_W-1], r_x0}) : '0;
    assign prod  = DIVN_W'($signed(diff) * $signed({1'b0, r_p}));
    assign q_ext = {1'b0, div_quo[SAMPLE_W-1:0]};
    assign val_ext = {r_x0[SAMPLE_W-1], r_x0} + (r_neg ? -q_ext : q_ext);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= RATE_RESET;
            r_tgt <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SOURCE_RATE: r_src <= i_cfg_wdata;
                REG_TARGET_RATE: r_tgt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= '0;
            r_k      <= '0;
            r_p      <= '0;
            r_wr     <= '0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
            r_eos    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_k      <= n_k;
            r_p      <= n_p;
            r_wr     <= n_wr;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
            r_eos    <= n_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_lim    <= n_lim;
        r_x0     <= n_x0;
        r_x1     <= n_x1;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_val    <= n_val;
        r_hold_d <= n_hold_d;
        r_od     <= n_od;
        r_olast  <= n_olast;
        r_ouser  <= n_ouser;
    end

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_k       = r_k;
        n_p       = r_p;
        n_wr      = r_wr;
        n_cnt     = r_cnt;
        n_eos     = r_eos;
        n_d       = r_d;
        n_lim     = r_lim;
        n_x0      = r_x0;
        n_x1      = r_x1;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_val     = r_val;
        n_hold_v  = r_hold_v;
        n_hold_d  = r_hold_d;
        n_ov      = r_ov && !i_m_axis_tready;
        n_od      = r_od;
        n_olast   = r_olast;
        n_ouser   = r_ouser;
        mem_we    = 1'b0;
        mem_raddr = r_wr - r_d[RING_AW-1:0];
        div_start = 1'b0;
        div_num   = DIVN_W'(r_p);
        div_qbits = QB_FOLD;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_eos = i_s_axis_tlast;
                    n_cnt = '0;
                    if (ratio_bad) begin
                        n_state = ST_ERR;
                    end else begin
                        mem_we  = 1'b1;
                        n_wr    = r_wr + RING_AW'(1);
                        n_seen  = r_seen + CNT_W'(1);
                        n_state = ST_FOLD;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_od    = '0;
                    n_olast = 1'b1;
                    n_ouser = {1'b1, r_eos};
                    if (r_eos) begin
                        n_seen = '0;
                        n_k    = '0;
                        n_p    = '0;
                        n_wr   = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_FOLD: begin
                // a rate change may have left the phase at or above target
                if (r_p >= r_tgt) begin
                    div_start = 1'b1;
                    n_state   = ST_FOLD_WAIT;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_FOLD_WAIT: begin
                if (!div_busy) begin
                    n_k     = r_k + CNT_W'(div_quo);
                    n_p     = div_rem;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                // distance wraps at the counter width before widening
                n_d   = r_seen - r_k;
                n_lim = LIM_W'(n_d) * LIM_W'(r_tgt);
                n_state = (r_cnt == CAP_W'(RESULT_CAP)) ? ST_FIN : ST_CMP;
            end
            ST_CMP: begin
                if (r_d == '0 || (!r_eos && r_d < CNT_W'(2))
                    || LIM_W'(p_next) > r_lim) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                mem_raddr = r_wr - r_d[RING_AW-1:0] + RING_AW'(1);
                n_x0      = mem_rdata;
                n_state   = ST_RD1;
            end
            ST_RD1: begin
                n_x1    = mem_rdata;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_neg   = prod[DIVN_W-1];
                n_mag   = prod[DIVN_W-1] ? -prod : prod;
                n_state = ST_IDIV;
            end
            ST_IDIV: begin
                div_start = 1'b1;
                div_num   = r_mag;
                div_qbits = QB_INTERP;
                n_state   = ST_IDIV_WAIT;
            end
            ST_IDIV_WAIT: begin
                if (!div_busy) begin
                    n_val   = val_ext[SAMPLE_W-1:0];
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_ov    = 1'b1;
                        n_od    = r_hold_d;
                        n_olast = 1'b0;
                        n_ouser = '0;
                    end
                    n_hold_v  = 1'b1;
                    n_hold_d  = r_val;
                    n_cnt     = r_cnt + CAP_W'(1);
                    div_start = 1'b1;
                    div_num   = DIVN_W'(p_next);
                    div_qbits = QB_STEP;
                    n_state   = ST_SDIV_WAIT;
                end
            end
            ST_SDIV_WAIT: begin
                if (!div_busy) begin
                    n_k     = r_k + CNT_W'(div_quo);
                    n_p     = div_rem;
                    n_state = ST_CHK;
                end
            end
            ST_FIN: begin
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_ov    = 1'b1;
                        n_od    = r_hold_d;
                        n_olast = 1'b1;
                        n_ouser = {1'b0, r_eos};
                    end
                    n_hold_v = 1'b0;
                    if (r_eos) begin
                        n_seen = '0;
                        n_k    = '0;
                        n_p    = '0;
                        n_wr   = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    lir_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_tgt),
        .i_qbits (div_qbits),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;

endmodule

@@ rtl/lir_checker.sv @@
// Port-level checks for the resampler, bound to the top level.
// Depends on lir_pkg and linear_interp_resampler.
module lir_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [lir_pkg::SAMPLE_W-1:0]      i_m_tdata,
    input  logic                              i_m_tlast,
    input  logic [lir_pkg::TUSER_W-1:0]       i_m_tuser
);
    import lir_pkg::*;

    // an offered result stays valid until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("output dropped while stalled");

    // one input at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken while busy");

    // ratio error is a lone zero result
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |-> i_m_tlast && i_m_tdata == '0)
        else $error("malformed ratio error result");

    // stream end only on a run end
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> i_m_tlast)
        else $error("stream end without run end");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tuser  (o_m_axis_tuser)
);
